>>> design/bounded_unordered_set_table_unit_defines.svh
// Assertion macros used by the set table datapath.
// Depends on nothing. Users must have clk and arst_n in scope.
`ifndef BOUNDED_UNORDERED_SET_TABLE_UNIT_DEFINES_SVH
`define BOUNDED_UNORDERED_SET_TABLE_UNIT_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define BUST_ASSERT_IMPL(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("set table assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define BUST_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("set table assertion failed");

`endif

>>> design/bust_pkg.sv
// Shared constants, command codes and control structs of the set table.
// Used by the controller, the datapath and the top level.
package bust_pkg;

	localparam int CAPACITY = 8;
	localparam int ADDR_W   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CNT_W    = $clog2(CAPACITY + 1);
	localparam int VAL_W    = 32;
	localparam int CMD_W    = 2;
	localparam int POS_W    = 4;
	localparam int OCC_W    = 4;

	localparam int IN_FIELDS_W  = CMD_W + VAL_W;
	localparam int IN_TDATA_W   = ((IN_FIELDS_W + 7) / 8) * 8;
	localparam int OUT_FIELDS_W = 1 + POS_W + VAL_W + OCC_W;
	localparam int OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;
	localparam int OUT_PAD_W    = OUT_TDATA_W - OUT_FIELDS_W;

	localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
	localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd1;
	localparam logic [CMD_W-1:0] CMD_SEARCH = 2'd2;
	localparam logic [CMD_W-1:0] CMD_POP    = 2'd3;

	localparam logic [POS_W-1:0] POS_NONE = '1;

	typedef struct packed {
		logic load;
		logic scan;
		logic rd_last;
		logic apply;
	} bust_cmd_t;

	typedef struct packed {
		logic scan_done;
		logic scan_hit;
	} bust_stat_t;

endpackage

>>> design/bust_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Depends on nothing.
module bust_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 8
) (
	input  logic                                      clk,
	input  logic                                      we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                          wdata,
	input  logic                                      re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                          rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

>>> design/bust_ctrl.sv
// Controller state machine of the set table: sequences load, scan, last-entry read and apply.
// Depends on bust_pkg.
module bust_ctrl import bust_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	input  logic [CMD_W-1:0] in_op,
	output logic             in_ready,
	output logic             out_valid,
	input  logic             out_ready,
	input  bust_stat_t       stat,
	output bust_cmd_t        cmd
);

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_SCAN  = 2'd1;
	localparam logic [1:0] ST_LAST  = 2'd2;
	localparam logic [1:0] ST_APPLY = 2'd3;

	logic [1:0] state_q;
	logic [1:0] state_d;
	logic       op_remove_q;
	logic       out_valid_q;
	logic       accept;
	logic       apply;

	assign in_ready = (state_q == ST_IDLE);
	assign accept   = in_valid && in_ready;
	assign apply    = (state_q == ST_APPLY) && (!out_valid_q || out_ready);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					state_d = (in_op == CMD_POP) ? ST_LAST : ST_SCAN;
				end
			end
			ST_SCAN: begin
				if (stat.scan_done) begin
					state_d = (op_remove_q && stat.scan_hit) ? ST_LAST : ST_APPLY;
				end
			end
			ST_LAST: begin
				state_d = ST_APPLY;
			end
			ST_APPLY: begin
				if (apply) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			op_remove_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (accept) begin
				op_remove_q <= (in_op == CMD_REMOVE);
			end
			if (apply) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid   = out_valid_q;
	assign cmd.load    = accept;
	assign cmd.scan    = (state_q == ST_SCAN);
	assign cmd.rd_last = (state_q == ST_LAST);
	assign cmd.apply   = apply;

endmodule

>>> design/bust_datapath.sv
// Datapath of the set table: entry RAM, count, scan pointer, compare and result registers.
// Depends on bust_pkg, bust_ram and the assertion macros header.
`include "bounded_unordered_set_table_unit_defines.svh"

module bust_datapath import bust_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  bust_cmd_t        cmd,
	output bust_stat_t       stat,
	input  logic [CMD_W-1:0] in_op,
	input  logic [VAL_W-1:0] in_value,
	output logic             success,
	output logic [POS_W-1:0] position,
	output logic [VAL_W-1:0] popped_value,
	output logic [OCC_W-1:0] occupancy
);

	logic [CMD_W-1:0]  op_q;
	logic [VAL_W-1:0]  val_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [CNT_W-1:0]  cnt_d;
	logic [CNT_W-1:0]  idx_q;
	logic              cmpv_q;
	logic              started_q;
	logic [ADDR_W-1:0] cmp_slot_q;
	logic [ADDR_W-1:0] fslot_q;
	logic              found_q;

	logic              succ_q;
	logic [POS_W-1:0]  pos_q;
	logic [VAL_W-1:0]  pop_q;
	logic [OCC_W-1:0]  occ_q;

	logic              ram_we;
	logic [ADDR_W-1:0] ram_waddr;
	logic [VAL_W-1:0]  ram_wdata;
	logic              ram_re;
	logic [ADDR_W-1:0] ram_raddr;
	logic [VAL_W-1:0]  ram_rdata;

	logic              hit_now;
	logic              idx_live;
	logic              ok;
	logic [POS_W-1:0]  pos_d;
	logic [VAL_W-1:0]  pop_d;

	bust_ram #(
		.WIDTH(VAL_W),
		.DEPTH(CAPACITY)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	assign hit_now        = cmpv_q && (ram_rdata == val_q);
	assign idx_live       = (idx_q < cnt_q);
	assign stat.scan_hit  = hit_now;
	assign stat.scan_done = hit_now || (started_q && !cmpv_q);

	assign ram_re    = cmd.scan || cmd.rd_last;
	assign ram_raddr = cmd.rd_last ? ADDR_W'(cnt_q - CNT_W'(1)) : ADDR_W'(idx_q);

	always_comb begin
		ok        = 1'b0;
		cnt_d     = cnt_q;
		pos_d     = POS_NONE;
		pop_d     = '0;
		ram_we    = 1'b0;
		ram_waddr = ADDR_W'(cnt_q);
		ram_wdata = val_q;
		unique case (op_q)
			CMD_INSERT: begin
				ok     = !found_q && (cnt_q < CNT_W'(CAPACITY));
				ram_we = cmd.apply && ok;
				if (ok) begin
					cnt_d = cnt_q + CNT_W'(1);
				end
			end
			CMD_REMOVE: begin
				ok        = found_q;
				ram_we    = cmd.apply && ok;
				ram_waddr = fslot_q;
				ram_wdata = ram_rdata;
				if (ok) begin
					cnt_d = cnt_q - CNT_W'(1);
				end
			end
			CMD_SEARCH: begin
				ok = found_q;
				if (ok) begin
					pos_d = POS_W'(fslot_q);
				end
			end
			CMD_POP: begin
				ok = (cnt_q != '0);
				if (ok) begin
					cnt_d = cnt_q - CNT_W'(1);
					pop_d = ram_rdata;
				end
			end
			default: begin
				ok = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q     <= '0;
			idx_q     <= '0;
			cmpv_q    <= 1'b0;
			started_q <= 1'b0;
			found_q   <= 1'b0;
		end else begin
			if (cmd.load) begin
				idx_q     <= '0;
				cmpv_q    <= 1'b0;
				started_q <= 1'b0;
			end else if (cmd.scan) begin
				cmpv_q    <= idx_live;
				started_q <= 1'b1;
				found_q   <= hit_now;
				if (idx_live) begin
					idx_q <= idx_q + CNT_W'(1);
				end
			end
			if (cmd.apply) begin
				cnt_q <= cnt_d;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q  <= in_op;
			val_q <= in_value;
		end
		if (cmd.scan) begin
			cmp_slot_q <= ADDR_W'(idx_q);
			fslot_q    <= cmp_slot_q;
		end
		if (cmd.apply) begin
			succ_q <= ok;
			pos_q  <= pos_d;
			pop_q  <= pop_d;
			occ_q  <= OCC_W'(cnt_d);
		end
	end

	assign success      = succ_q;
	assign position     = pos_q;
	assign popped_value = pop_q;
	assign occupancy    = occ_q;

	`BUST_ASSERT_IMPL(a_cnt_bound, 1'b1, cnt_q <= CNT_W'(CAPACITY))
	`BUST_ASSERT_IMPL(a_write_on_apply, ram_we, cmd.apply)
	`BUST_ASSERT_NEXT(a_cnt_hold, !cmd.apply, $stable(cnt_q))
	`BUST_ASSERT_IMPL(a_scan_ptr, cmd.scan, idx_q <= cnt_q)

endmodule

>>> design/bounded_unordered_set_table_unit.sv
// Set table top level: pop reads the last stored entry, while insert, search and remove first
// scan the entries; the scan reads one stored entry per cycle from the entry RAM.
// One word is in work at a time; the next word is taken once the result is registered,
// even while that result still waits on the output side.
// Reset clears the entry count and the handshake state; the entry RAM is not cleared.
// Depends on bust_pkg, bust_ctrl and bust_datapath.
module bounded_unordered_set_table_unit import bust_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_axis_tvalid,
	output logic                   s_axis_tready,
	// [1:0] command, [33:2] value, zero padding above.
	input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
	output logic                   m_axis_tvalid,
	input  logic                   m_axis_tready,
	// [0] success, [4:1] position, [36:5] popped_value, [40:37] occupancy, zeros above.
	output logic [OUT_TDATA_W-1:0] m_axis_tdata
);

	bust_cmd_t        cmd;
	bust_stat_t       stat;
	logic [CMD_W-1:0] in_op;
	logic [VAL_W-1:0] in_value;
	logic             success;
	logic [POS_W-1:0] position;
	logic [VAL_W-1:0] popped_value;
	logic [OCC_W-1:0] occupancy;

	assign in_op    = s_axis_tdata[CMD_W-1:0];
	assign in_value = s_axis_tdata[CMD_W+VAL_W-1:CMD_W];

	bust_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_op    (in_op),
		.in_ready (s_axis_tready),
		.out_valid(m_axis_tvalid),
		.out_ready(m_axis_tready),
		.stat     (stat),
		.cmd      (cmd)
	);

	bust_datapath u_datapath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.stat        (stat),
		.in_op       (in_op),
		.in_value    (in_value),
		.success     (success),
		.position    (position),
		.popped_value(popped_value),
		.occupancy   (occupancy)
	);

	assign m_axis_tdata = {{OUT_PAD_W{1'b0}}, occupancy, popped_value, position, success};

endmodule
